// ----- design/quadratic_root_solver_defines.svh -----
// Assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef ASSERT_OFF
`define QRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define QRS_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define QRS_ASSERT(label, clk, rst_n, prop)
`define QRS_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- design/qrs_pkg.sv -----
// Shared types and constants for the quadratic root solver
`default_nettype none
package qrs_pkg;
    localparam int unsigned CoefW = 32;
    localparam int unsigned DiscW = 66;
    localparam int unsigned RootW = 33;
    localparam int unsigned SqrtSteps = 33;

    typedef enum logic [2:0] {
        CASE_TWO      = 3'd0,
        CASE_DOUBLE   = 3'd1,
        CASE_NONE     = 3'd2,
        CASE_LINEAR   = 3'd3,
        CASE_IDENTITY = 3'd4,
        CASE_IMPOSS   = 3'd5
    } t_case;
endpackage
`default_nettype wire

// ----- design/qrs_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband
`default_nettype none
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int unsigned SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [DiscW-1:0]  i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [RootW-1:0]       o_root,
    output logic [SIDE_W-1:0]      o_side
);
    // restoring sqrt: stage k decides root bit (32-k)
    logic [SqrtSteps:0]    r_vld;
    logic [DiscW+1:0]      r_rem  [SqrtSteps+1];
    logic [RootW-1:0]      r_root [SqrtSteps+1];
    logic [DiscW-1:0]      r_rad  [SqrtSteps+1];
    logic [SIDE_W-1:0]     r_side [SqrtSteps+1];

    assign r_vld[0]  = i_valid;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_rad[0]  = i_rad;
    assign r_side[0] = i_side;

    genvar k;
    generate
        for (k = 0; k < SqrtSteps; k++) begin : g_stage
            logic [DiscW+1:0] w_rem;
            logic [DiscW+1:0] w_trial;
            always_comb begin
                w_rem   = {r_rem[k][DiscW-1:0], r_rad[k][DiscW-1 -: 2]};
                w_trial = {{(DiscW+2-RootW-2){1'b0}}, r_root[k], 2'b01};
            end
            logic              s_vld;
            logic [DiscW+1:0]  s_rem;
            logic [RootW-1:0]  s_root;
            logic [DiscW-1:0]  s_rad;
            logic [SIDE_W-1:0] s_side;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    s_vld <= 1'b0;
                end else begin
                    s_vld <= r_vld[k];
                end
                if (w_rem >= w_trial) begin
                    s_rem  <= w_rem - w_trial;
                    s_root <= {r_root[k][RootW-2:0], 1'b1};
                end else begin
                    s_rem  <= w_rem;
                    s_root <= {r_root[k][RootW-2:0], 1'b0};
                end
                s_rad  <= {r_rad[k][DiscW-3:0], 2'b00};
                s_side <= r_side[k];
            end
            assign r_vld[k+1]  = s_vld;
            assign r_rem[k+1]  = s_rem;
            assign r_root[k+1] = s_root;
            assign r_rad[k+1]  = s_rad;
            assign r_side[k+1] = s_side;
        end
    endgenerate

    assign o_valid = r_vld[SqrtSteps];
    assign o_root  = r_root[SqrtSteps];
    assign o_side  = r_side[SqrtSteps];
endmodule
`default_nettype wire

// ----- design/qrs_div.sv -----
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating
`default_nettype none
module qrs_div
    import qrs_pkg::*;
#(
    parameter int unsigned NUM_W  = 34,
    parameter int unsigned DEN_W  = 33,
    parameter int unsigned FRAC   = 16,
    parameter int unsigned SIDE_W = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic signed [DEN_W-1:0] i_den,
    input  wire logic [SIDE_W-1:0]       i_side,
    output logic                         o_valid,
    output logic [CoefW-1:0]             o_quot,
    output logic                         o_sat,
    output logic [SIDE_W-1:0]            o_side
);
    // dividend |num|<<FRAC; quotient kept to QW bits, above that saturates
    localparam int unsigned DW = NUM_W + FRAC;
    localparam int unsigned QW = CoefW + 1;
    localparam int unsigned RW = DEN_W + 1;

    logic             w_neg;
    logic [DW-1:0]    w_dvd;
    logic [DEN_W-1:0] w_dmag;
    logic [NUM_W-1:0] w_nmag;
    always_comb begin
        w_neg  = i_num[NUM_W-1] ^ i_den[DEN_W-1];
        w_nmag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        w_dmag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        w_dvd  = {w_nmag, {FRAC{1'b0}}};
    end

    // pre-check: quotient fits QW bits iff (dvd >> QW) < den
    logic r0_vld, r0_neg, r0_big;
    logic [DW-1:0]    r0_dvd;
    logic [DEN_W-1:0] r0_den;
    logic [SIDE_W-1:0] r0_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_vld <= 1'b0;
        else r0_vld <= i_valid;
        r0_neg  <= w_neg;
        r0_big  <= ({{QW{1'b0}}, w_dvd} >> QW) >= (DW+QW)'(w_dmag);
        r0_dvd  <= w_dvd;
        r0_den  <= w_dmag;
        r0_side <= i_side;
    end

    logic [QW:0]       s_vld;
    logic [RW-1:0]     s_rem  [QW+1];
    logic [QW-1:0]     s_q    [QW+1];
    logic [DW-1:0]     s_dvd  [QW+1];
    logic [DEN_W-1:0]  s_den  [QW+1];
    logic              s_neg  [QW+1];
    logic              s_big  [QW+1];
    logic [SIDE_W-1:0] s_side [QW+1];

    assign s_vld[0]  = r0_vld;
    // bits above the QW quotient bits form the starting remainder (< den)
    assign s_rem[0]  = RW'(r0_dvd >> QW);
    assign s_q[0]    = '0;
    assign s_dvd[0]  = r0_dvd << (DW - QW);
    assign s_den[0]  = r0_den;
    assign s_neg[0]  = r0_neg;
    assign s_big[0]  = r0_big;
    assign s_side[0] = r0_side;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [RW-1:0] w_t;
            logic          w_ge;
            always_comb begin
                w_t  = {s_rem[k][RW-2:0], s_dvd[k][DW-1]};
                w_ge = w_t >= RW'(s_den[k]);
            end
            logic              x_vld, x_neg, x_big;
            logic [RW-1:0]     x_rem;
            logic [QW-1:0]     x_q;
            logic [DW-1:0]     x_dvd;
            logic [DEN_W-1:0]  x_den;
            logic [SIDE_W-1:0] x_side;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) x_vld <= 1'b0;
                else x_vld <= s_vld[k];
                x_rem  <= w_ge ? w_t - RW'(s_den[k]) : w_t;
                x_q    <= {s_q[k][QW-2:0], w_ge};
                x_dvd  <= {s_dvd[k][DW-2:0], 1'b0};
                x_den  <= s_den[k];
                x_neg  <= s_neg[k];
                x_big  <= s_big[k];
                x_side <= s_side[k];
            end
            assign s_vld[k+1]  = x_vld;
            assign s_rem[k+1]  = x_rem;
            assign s_q[k+1]    = x_q;
            assign s_dvd[k+1]  = x_dvd;
            assign s_den[k+1]  = x_den;
            assign s_neg[k+1]  = x_neg;
            assign s_big[k+1]  = x_big;
            assign s_side[k+1] = x_side;
        end
    endgenerate

    // sign and saturate
    logic [QW-1:0] w_qm;
    logic          w_qneg, w_qbig;
    always_comb begin
        w_qm   = s_q[QW];
        w_qneg = s_neg[QW];
        w_qbig = s_big[QW];
        o_valid = s_vld[QW];
        o_side  = s_side[QW];
        if (!w_qneg) begin
            // positive range ends at 2^31 - 1
            o_sat  = w_qbig || (w_qm[QW-1:CoefW-1] != '0);
            o_quot = o_sat ? {1'b0, {(CoefW-1){1'b1}}} : w_qm[CoefW-1:0];
        end else begin
            o_sat  = w_qbig || (w_qm > QW'({1'b1, {(CoefW-1){1'b0}}}));
            o_quot = o_sat ? {1'b1, {(CoefW-1){1'b0}}} : CoefW'(-w_qm);
        end
    end
endmodule
`default_nettype wire

// ----- design/quadratic_root_solver.sv -----
// Top level of the quadratic root solver pipeline
`default_nettype none
// Quadratic root solver: real roots of a*x^2 + b*x + c = 0 in signed
// fixed point with FRAC_BITS fraction bits.
// Input channel: drive i_coef_quad, i_coef_lin, i_coef_const and raise
// start; the set transfers on any edge where start is high. busy is
// tied low: the pipeline takes one coefficient set every cycle.
// Output channel: done pulses for one cycle with o_root_first,
// o_root_second, o_case_code and o_overflow. The receiver cannot hold
// results off, so nothing ever stalls; results leave in order.
// The pipeline: setup registers (multiply, discriminant), then 33
// square-root stages (one root bit each), then the dividers: 1 range
// check plus 33 quotient stages, and one output register.
// The depth is set by the bit-serial square root and divider chains.
// Cases without a square root or divide still flow through the same
// stages, so order and latency stay uniform.
// Reset clears all valid bits; in-flight items are dropped.
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [CoefW-1:0] i_coef_quad,
    input  wire logic signed [CoefW-1:0] i_coef_lin,
    input  wire logic signed [CoefW-1:0] i_coef_const,
    output logic                         done,
    output logic signed [CoefW-1:0]      o_root_first,
    output logic signed [CoefW-1:0]      o_root_second,
    output logic [2:0]                   o_case_code,
    output logic                         o_overflow
);
    localparam int unsigned NumW = 35;
    localparam int unsigned DenW = 34;
    // sideband: case, use-divider flags, linear and zero-c flags, a, b, c
    typedef struct packed {
        t_case             code;
        logic              div1;
        logic              div2;
        logic              lin;
        logic              zc;
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        logic signed [CoefW-1:0] c;
    } t_side;
    localparam int unsigned SideW = $bits(t_side);

    assign busy = 1'b0;

    // stage 1: register inputs, form |b|^2 and |a||c| products
    logic r1_vld;
    logic signed [CoefW-1:0] r1_a, r1_b, r1_c;
    logic [63:0] r1_bb, r1_ac;
    logic [CoefW-1:0] w_ma, w_mb, w_mc;
    always_comb begin
        w_ma = i_coef_quad[CoefW-1] ? -i_coef_quad : i_coef_quad;
        w_mb = i_coef_lin[CoefW-1] ? -i_coef_lin : i_coef_lin;
        w_mc = i_coef_const[CoefW-1] ? -i_coef_const : i_coef_const;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else r1_vld <= start;
        r1_a  <= i_coef_quad;
        r1_b  <= i_coef_lin;
        r1_c  <= i_coef_const;
        r1_bb <= 64'(w_mb) * 64'(w_mb);
        r1_ac <= 64'(w_ma) * 64'(w_mc);
    end

    // stage 2: discriminant and case selection
    logic [DiscW-1:0] w_sq, w_4ac, w_d;
    logic             w_neg;
    t_side            w_side;
    always_comb begin
        w_sq  = DiscW'(r1_bb);
        w_4ac = {r1_ac, 2'b00};
        w_neg = 1'b0;
        w_d   = '0;
        if (r1_a[CoefW-1] != r1_c[CoefW-1]) w_d = w_sq + w_4ac;
        else if (w_sq >= w_4ac)             w_d = w_sq - w_4ac;
        else                                w_neg = 1'b1;
        w_side.a = r1_a;
        w_side.b = r1_b;
        w_side.c = r1_c;
        w_side.div1 = 1'b0;
        w_side.div2 = 1'b0;
        w_side.lin  = 1'b0;
        w_side.zc   = 1'b0;
        if (r1_a == '0) begin
            if (r1_b != '0) begin
                w_side.code = CASE_LINEAR;
                w_side.div1 = 1'b1;
                w_side.lin  = 1'b1;
            end else if (r1_c == '0) begin
                w_side.code = CASE_IDENTITY;
            end else begin
                w_side.code = CASE_IMPOSS;
            end
        end else if (r1_c == '0) begin
            if (r1_b != '0) begin
                w_side.code = CASE_TWO;
                w_side.div1 = 1'b1;
                w_side.zc   = 1'b1;
            end else begin
                w_side.code = CASE_DOUBLE;
            end
        end else if (w_neg) begin
            w_side.code = CASE_NONE;
        end else if (w_d == '0) begin
            w_side.code = CASE_DOUBLE;
            w_side.div1 = 1'b1;
            w_side.div2 = 1'b1;
        end else begin
            w_side.code = CASE_TWO;
            w_side.div1 = 1'b1;
            w_side.div2 = 1'b1;
        end
    end

    logic             r2_vld;
    logic [DiscW-1:0] r2_d;
    t_side            r2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else r2_vld <= r1_vld;
        r2_d    <= w_d;
        r2_side <= w_side;
    end

    // square-root pipeline
    logic              q_vld;
    logic [RootW-1:0]  q_root;
    logic [SideW-1:0]  q_side_bits;
    t_side             q_side;
    qrs_sqrt #(.SIDE_W(SideW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_rad   (r2_d),
        .i_side  (r2_side),
        .o_valid (q_vld),
        .o_root  (q_root),
        .o_side  (q_side_bits)
    );
    assign q_side = t_side'(q_side_bits);

    // numerators and denominator per case
    logic signed [NumW-1:0] w_n1, w_n2, w_nb, w_s;
    logic signed [DenW-1:0] w_den;
    always_comb begin
        w_nb = -NumW'(q_side.b);
        w_s  = NumW'({1'b0, q_root});
        if (q_side.lin) begin
            w_n1  = -NumW'(q_side.c);
            w_n2  = '0;
            w_den = DenW'(q_side.b);
        end else if (q_side.zc) begin
            w_n1  = w_nb;
            w_n2  = '0;
            w_den = DenW'(q_side.a);
        end else begin
            w_n1  = w_nb + w_s;
            w_n2  = w_nb - w_s;
            w_den = DenW'(q_side.a) <<< 1;
        end
    end

    logic              d1_vld, d2_vld, d1_sat, d2_sat;
    logic [CoefW-1:0]  d1_q, d2_q;
    logic [SideW-1:0]  d1_side_bits, d2_side_unused;
    t_side             d1_side;
    qrs_div #(.NUM_W(NumW), .DEN_W(DenW), .FRAC(FRAC_BITS), .SIDE_W(SideW)) u_div1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (q_vld),
        .i_num (w_n1), .i_den (w_den), .i_side (q_side),
        .o_valid (d1_vld), .o_quot (d1_q), .o_sat (d1_sat), .o_side (d1_side_bits)
    );
    qrs_div #(.NUM_W(NumW), .DEN_W(DenW), .FRAC(FRAC_BITS), .SIDE_W(SideW)) u_div2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (q_vld),
        .i_num (w_n2), .i_den (w_den), .i_side (q_side),
        .o_valid (d2_vld), .o_quot (d2_q), .o_sat (d2_sat), .o_side (d2_side_unused)
    );
    assign d1_side = t_side'(d1_side_bits);

    // output register: gate unused roots to zero
    logic             r_done, n_done;
    logic [CoefW-1:0] r_r1, r_r2, n_r1, n_r2;
    logic [2:0]       r_code;
    logic             r_ovf, n_ovf;
    always_comb begin
        n_done = d1_vld;
        n_r1   = d1_side.div1 ? d1_q : '0;
        n_r2   = d1_side.div2 ? d2_q : '0;
        n_ovf  = (d1_side.div1 && d1_sat) || (d1_side.div2 && d2_sat);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= n_done;
        r_r1   <= n_r1;
        r_r2   <= n_r2;
        r_code <= d1_side.code;
        r_ovf  <= n_ovf;
    end

    assign done          = r_done;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;
    assign o_case_code   = r_code;
    assign o_overflow    = r_ovf;

    `QRS_ASSERT(a_div_lockstep, i_clk, i_rst_n, d1_vld == d2_vld)
    `QRS_ASSERT(a_ovf_has_root, i_clk, i_rst_n, done && o_overflow |-> (o_case_code == CASE_TWO || o_case_code == CASE_DOUBLE || o_case_code == CASE_LINEAR))
    `QRS_ASSERT(a_noroot_zero, i_clk, i_rst_n, done && (o_case_code == CASE_NONE || o_case_code == CASE_IDENTITY || o_case_code == CASE_IMPOSS) |-> (o_root_first == '0 && o_root_second == '0 && !o_overflow))
endmodule
`default_nettype wire
